### hdl/positional_list_insert_delete_macros.svh
// ----------------------------------------------------------------------------
// Positional list assertion macros
// Concurrent assertion helpers shared by the positional list RTL.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH

`ifndef SYNTHESIS
// Assertion checked on every rising clock edge outside of reset.
`define PLD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion checked on every rising clock edge, reset included.
`define PLD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLD_ASSERT(lbl, clk, rst_n, prop, msg)
`define PLD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### hdl/pld_pkg.sv
// ----------------------------------------------------------------------------
// Positional list package
// Shared widths, operation codes and status codes of the positional list.
// ----------------------------------------------------------------------------
`default_nettype none

package pld_pkg;

    // Default number of list entries.
    localparam int unsigned DEFAULT_CAPACITY = 8;

    // Field widths of the item channels.
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 4;

    // Operation codes.
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

endpackage

`default_nettype wire

### hdl/positional_list_insert_delete.sv
// Items are taken only while the sequencer is idle, one at a time; each entry
// moved costs a read step and a write step on the entry memory.
// Reset (aresetn, synchronous, active low) empties the list and clears the
// control state; entry memory contents are left as they are.
// ----------------------------------------------------------------------------
// Positional list with insert and delete
// Ordered list of signed values held in one memory; inserts and deletes
// shift the trailing entries one at a time through read-modify-write steps.
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_list_insert_delete_macros.svh"

module positional_list_insert_delete
    import pld_pkg::*;
#(
    parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_func,
    input  wire logic        [POS_W-1:0]    s_position,
    input  wire logic signed [VALUE_W-1:0]  s_value,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic             [STATUS_W-1:0] m_status,
    output logic signed      [VALUE_W-1:0]  m_removed_value,
    output logic             [COUNT_W-1:0]  m_entry_count
);

    localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_WR    = 3'd2;
    localparam logic [2:0] S_PUT   = 3'd3;
    localparam logic [2:0] S_FETCH = 3'd4;
    localparam logic [2:0] S_CAPT  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]                  state_reg, state_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [AW-1:0]               dst_reg, dst_next;
    logic                        func_reg, func_next;
    logic [POS_W-1:0]            pos_reg, pos_next;
    logic signed [VALUE_W-1:0]   val_reg, val_next;
    logic [STATUS_W-1:0]         status_reg, status_next;
    logic signed [VALUE_W-1:0]   removed_reg, removed_next;
    logic                        m_valid_reg;
    logic [STATUS_W-1:0]         m_status_reg;
    logic signed [VALUE_W-1:0]   m_removed_reg;
    logic [CW-1:0]               m_count_reg;

    // Entry memory with a registered read port.
    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] rdata_reg;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;

    logic              s_accept;
    logic              out_load;
    logic [CMPW-1:0]   cnt_x;
    logic [CMPW-1:0]   pos_x;
    logic [CMPW-1:0]   dst_x;
    logic [CMPW-1:0]   pos_reg_x;
    logic [POS_W-1:0]  pos_m1;
    logic [CMPW-1:0]   m_count_x;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign out_load  = (state_reg == S_DONE) && (!m_valid_reg || m_ready);
    assign cnt_x     = CMPW'(count_reg);
    assign pos_x     = CMPW'(s_position);
    assign dst_x     = CMPW'(dst_reg);
    assign pos_reg_x = CMPW'(pos_reg);
    assign pos_m1    = s_position - POS_W'(1);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Memory port control: shift steps read one neighbor and write it into the current entry.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = dst_reg;
        wr_en   = 1'b0;
        wr_addr = dst_reg;
        wr_data = rdata_reg;
        unique case (state_reg)
            S_RD: begin
                rd_en   = 1'b1;
                rd_addr = (func_reg == FUNC_INSERT) ? dst_reg - AW'(1) : dst_reg + AW'(1);
            end
            S_FETCH: begin
                rd_en = 1'b1;
            end
            S_WR: begin
                wr_en = 1'b1;
            end
            S_PUT: begin
                wr_en   = 1'b1;
                wr_data = val_reg;
            end
            default: begin
            end
        endcase
    end

    // Sequencer next-state logic.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dst_next     = dst_reg;
        func_next    = func_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    func_next    = s_func;
                    pos_next     = s_position;
                    val_next     = s_value;
                    removed_next = '0;
                    state_next   = S_DONE;
                    if (s_func == FUNC_INSERT) begin
                        dst_next = count_reg[AW-1:0];
                        if (count_reg >= CW'(CAPACITY)) begin
                            status_next = ST_FULL;
                        end else if (pos_x == '0 || pos_x > cnt_x + CMPW'(1)) begin
                            status_next = ST_RANGE;
                        end else begin
                            status_next = ST_OK;
                            state_next  = (cnt_x >= pos_x) ? S_RD : S_PUT;
                        end
                    end else begin
                        dst_next = pos_m1[AW-1:0];
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else if (pos_x == '0 || pos_x > cnt_x) begin
                            status_next = ST_RANGE;
                        end else begin
                            status_next = ST_OK;
                            state_next  = S_FETCH;
                        end
                    end
                end
            end
            S_RD: begin
                state_next = S_WR;
            end
            S_WR: begin
                if (func_reg == FUNC_INSERT) begin
                    dst_next   = dst_reg - AW'(1);
                    state_next = (dst_x > pos_reg_x) ? S_RD : S_PUT;
                end else begin
                    dst_next   = dst_reg + AW'(1);
                    state_next = (dst_x + CMPW'(2) < cnt_x) ? S_RD : S_DONE;
                end
            end
            S_PUT: begin
                state_next = S_DONE;
            end
            S_FETCH: begin
                state_next = S_CAPT;
            end
            S_CAPT: begin
                removed_next = rdata_reg;
                state_next   = (dst_x + CMPW'(1) < cnt_x) ? S_RD : S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                    if (status_reg == ST_OK) begin
                        count_next = (func_reg == FUNC_INSERT) ? count_reg + CW'(1)
                                                               : count_reg - CW'(1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Per-item working registers.
    always_ff @(posedge aclk) begin
        dst_reg     <= dst_next;
        func_reg    <= func_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    // Result register: holds the finished item until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg  <= status_reg;
            m_removed_reg <= removed_reg;
            m_count_reg   <= count_next;
        end
    end

    assign m_count_x       = CMPW'(m_count_reg);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_removed_value = m_removed_reg;
    assign m_entry_count   = m_count_x[COUNT_W-1:0];

    // The list never holds more entries than it has room for.
    `PLD_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CW'(CAPACITY), "count exceeds capacity")
    // Entry memory is written only by shift and placement steps.
    `PLD_ASSERT(a_write_states, aclk, aresetn, wr_en |-> (state_reg == S_WR || state_reg == S_PUT), "memory write outside shift")
    // A refused item leaves the count alone.
    `PLD_ASSERT(a_refused_count, aclk, aresetn, (out_load && status_reg != ST_OK) |=> $stable(count_reg), "refused item changed count")
    // A refused or insert result carries a zero removed value.
    `PLD_ASSERT(a_removed_zero, aclk, aresetn, (out_load && (status_reg != ST_OK || func_reg == FUNC_INSERT)) |=> (m_removed_value == '0), "nonzero removed value")
    // No new item is taken while a result is being finished.
    `PLD_ASSERT(a_no_accept_busy, aclk, aresetn, (state_reg == S_DONE) |-> !s_ready, "item accepted while busy")

endmodule

`default_nettype wire

### bench/pld_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list result checker
// Watches both item channels of the positional list. Keeps its own copy of the
// list, works out the result of every accepted item and compares each
// accepted result, field by field, with the oldest one still pending.
// ----------------------------------------------------------------------------

module pld_list_checker
    import pld_pkg::*;
#(
    parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    input  wire logic                       s_ready,
    input  wire logic                       s_func,
    input  wire logic        [POS_W-1:0]    s_position,
    input  wire logic signed [VALUE_W-1:0]  s_value,
    input  wire logic                       m_valid,
    input  wire logic                       m_ready,
    input  wire logic        [STATUS_W-1:0] m_status,
    input  wire logic signed [VALUE_W-1:0]  m_removed_value,
    input  wire logic        [COUNT_W-1:0]  m_entry_count,
    output int                              fail_count,
    output int                              outstanding
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  removed_value;
        logic [COUNT_W-1:0]  entry_count;
    } list_result_t;

    // Shadow copy of the list and the results still owed by the block.
    logic [VALUE_W-1:0] list_entries [CAPACITY];
    int unsigned        list_len;
    list_result_t       owed_results [$];
    list_result_t       seen_result;
    list_result_t       want_result;
    list_result_t       next_result;

    initial begin
        fail_count  = 0;
        outstanding = 0;
        list_len    = 0;
    end

    // Applies one insert or delete to the shadow list and forms its result.
    task automatic apply_list_op(
        input  logic               func,
        input  logic [POS_W-1:0]   pos,
        input  logic [VALUE_W-1:0] val,
        output list_result_t       res
    );
        int unsigned i;
        res.status        = ST_OK;
        res.removed_value = '0;
        if (func == FUNC_INSERT) begin
            // Fullness wins over a bad position.
            if (list_len >= CAPACITY) begin
                res.status = ST_FULL;
            end else if (pos < 1 || pos > list_len + 1) begin
                res.status = ST_RANGE;
            end else begin
                for (i = list_len; i >= pos; i--) begin
                    list_entries[i] = list_entries[i - 1];
                end
                list_entries[pos - 1] = val;
                list_len++;
            end
        end else begin
            // Emptiness wins over a bad position.
            if (list_len == 0) begin
                res.status = ST_EMPTY;
            end else if (pos < 1 || pos > list_len) begin
                res.status = ST_RANGE;
            end else begin
                res.removed_value = list_entries[pos - 1];
                for (i = pos - 1; i + 1 < list_len; i++) begin
                    list_entries[i] = list_entries[i + 1];
                end
                list_len--;
            end
        end
        res.entry_count = list_len[COUNT_W-1:0];
    endtask

    // Compare finished results first, then predict the newly accepted item.
    always @(posedge aclk) begin
        if (!aresetn) begin
            list_len = 0;
            owed_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                seen_result.status        = m_status;
                seen_result.removed_value = m_removed_value;
                seen_result.entry_count   = m_entry_count;
                if (owed_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result with no item pending: status %0d removed %0d count %0d",
                                 $realtime, seen_result.status,
                                 $signed(seen_result.removed_value), seen_result.entry_count);
                    end
                end else begin
                    want_result = owed_results.pop_front();
                    if (seen_result.status !== want_result.status ||
                        seen_result.removed_value !== want_result.removed_value ||
                        seen_result.entry_count !== want_result.entry_count) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: mismatch: expected status %0d removed %0d count %0d, got status %0d removed %0d count %0d",
                                     $realtime, want_result.status,
                                     $signed(want_result.removed_value),
                                     want_result.entry_count, seen_result.status,
                                     $signed(seen_result.removed_value),
                                     seen_result.entry_count);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                apply_list_op(s_func, s_position, s_value, next_result);
                owed_results.push_back(next_result);
            end
        end
        outstanding = owed_results.size();
    end

endmodule

### bench/tb_positional_list_insert_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list testbench
// Drives directed and random insert and delete items into the positional list
// with random idling on both channels, a long receiver hold-off and pauses,
// and reports the verdict from the failure count of the checker.
// ----------------------------------------------------------------------------

module tb_positional_list_insert_delete
    import pld_pkg::*;
();

    localparam int unsigned LIST_CAP         = DEFAULT_CAPACITY;
    localparam int unsigned RANDOM_ITEMS     = 1625;
    localparam int unsigned QUIET_TAIL_ITEMS = 150;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES    = 4 * (2 * LIST_CAP + 2);
    localparam int unsigned CYCLE_LIMIT      = 500000;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic                       s_func;
    logic        [POS_W-1:0]    s_position;
    logic signed [VALUE_W-1:0]  s_value;
    logic                       m_valid;
    logic                       m_ready;
    logic        [STATUS_W-1:0] m_status;
    logic signed [VALUE_W-1:0]  m_removed_value;
    logic        [COUNT_W-1:0]  m_entry_count;

    int          fail_count;
    int          outstanding;
    int unsigned cycle_count;
    int unsigned long_holds_asked;
    int unsigned long_holds_served;
    logic        quiet_tail;
    // Fill level the stimulus expects, used to steer positions and to drain the list.
    int unsigned fill_guess;

    positional_list_insert_delete #(
        .CAPACITY(LIST_CAP)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_position     (s_position),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_removed_value(m_removed_value),
        .m_entry_count  (m_entry_count)
    );

    pld_list_checker #(
        .CAPACITY(LIST_CAP)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_position     (s_position),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_removed_value(m_removed_value),
        .m_entry_count  (m_entry_count),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Run limit.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result receiver: random stalls, calm stretches and requested long holds.
    initial begin
        int unsigned burst;
        int unsigned calm_left;
        m_ready           = 1'b0;
        long_holds_served = 0;
        calm_left         = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (long_holds_served != long_holds_asked) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                long_holds_served++;
                m_ready <= 1'b1;
            end else if (quiet_tail || calm_left != 0) begin
                m_ready <= 1'b1;
                if (calm_left != 0) begin
                    calm_left--;
                end
            end else if ($urandom_range(0, 49) == 0) begin
                calm_left = $urandom_range(20, 100);
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 15);
                m_ready <= 1'b0;
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offers one item and waits until it is accepted.
    task automatic issue_op(input logic func, input int unsigned pos, input logic [31:0] val);
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_func     <= func;
        s_position <= pos[POS_W-1:0];
        s_value    <= val;
        do @(posedge aclk); while (!s_ready);
        // Track the expected fill level for steering later positions.
        if (func == FUNC_INSERT) begin
            if (fill_guess < LIST_CAP && pos >= 1 && pos <= fill_guess + 1) begin
                fill_guess++;
            end
        end else if (fill_guess != 0 && pos >= 1 && pos <= fill_guess) begin
            fill_guess--;
        end
    endtask

    // Drops valid for a number of cycles.
    task automatic hold_input(input int unsigned cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    // Stops offering items until every result has come back.
    task automatic wait_all_results();
        hold_input(1);
        while (outstanding != 0) @(negedge aclk);
    endtask

    // Stimulus and verdict.
    initial begin
        int unsigned mode;
        int unsigned mode_left;
        int unsigned send_calm;
        int unsigned pick;
        int unsigned pos;
        logic        func;

        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_func           = FUNC_INSERT;
        s_position       = '0;
        s_value          = '0;
        quiet_tail       = 1'b0;
        long_holds_asked = 0;
        fill_guess       = 0;
        mode             = 0;
        mode_left        = 0;
        send_calm        = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Refusals on an empty list.
        issue_op(FUNC_DELETE, 1, $urandom);
        issue_op(FUNC_DELETE, 0, $urandom);
        issue_op(FUNC_INSERT, 0, $urandom);
        issue_op(FUNC_INSERT, 2, $urandom);
        issue_op(FUNC_INSERT, 255, $urandom);
        // Fill with the value extremes at the front, middle and end.
        issue_op(FUNC_INSERT, 1, 32'h8000_0000);
        issue_op(FUNC_INSERT, 2, 32'h7FFF_FFFF);
        issue_op(FUNC_INSERT, 1, 32'hFFFF_FFFF);
        issue_op(FUNC_INSERT, 2, 32'h0000_0000);
        issue_op(FUNC_INSERT, 5, $urandom);
        issue_op(FUNC_INSERT, 3, $urandom);
        issue_op(FUNC_INSERT, 1, $urandom);
        issue_op(FUNC_INSERT, 8, $urandom);
        // A full list refuses inserts whatever the position.
        issue_op(FUNC_INSERT, 9, $urandom);
        issue_op(FUNC_INSERT, 0, $urandom);
        issue_op(FUNC_INSERT, 255, $urandom);
        // Deletes outside the list.
        issue_op(FUNC_DELETE, 0, $urandom);
        issue_op(FUNC_DELETE, 9, $urandom);
        issue_op(FUNC_DELETE, 255, $urandom);
        issue_op(FUNC_DELETE, 128, $urandom);
        // Deletes at the end, the front and the middle, then drain.
        issue_op(FUNC_DELETE, 8, $urandom);
        issue_op(FUNC_DELETE, 1, $urandom);
        issue_op(FUNC_DELETE, 3, $urandom);
        while (fill_guess != 0) begin
            issue_op(FUNC_DELETE, 1, $urandom);
        end
        wait_all_results();

        // Random phases that fill, drain or mix, mostly with valid positions.
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            if (n == RANDOM_ITEMS / 3) begin
                long_holds_asked++;
            end
            if (n == RANDOM_ITEMS / 2) begin
                wait_all_results();
            end
            if (n == RANDOM_ITEMS - QUIET_TAIL_ITEMS) begin
                quiet_tail = 1'b1;
            end

            pick = $urandom_range(0, 99);
            case (mode)
                0: func = (pick < 80) ? FUNC_INSERT : FUNC_DELETE;
                1: func = (pick < 80) ? FUNC_DELETE : FUNC_INSERT;
                default: func = (pick < 50) ? FUNC_INSERT : FUNC_DELETE;
            endcase

            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                if (func == FUNC_INSERT) begin
                    pos = $urandom_range(1, fill_guess + 1);
                end else begin
                    pos = $urandom_range(1, (fill_guess == 0) ? 1 : fill_guess);
                end
            end else if (pick < 88) begin
                pos = 0;
            end else if (pick < 96) begin
                pos = $urandom_range(fill_guess + 2, 255);
            end else begin
                pos = 255;
            end
            issue_op(func, pos, $urandom);

            // Sender gaps, with calm stretches and none in the tail.
            if (send_calm != 0) begin
                send_calm--;
            end else if (!quiet_tail) begin
                if ($urandom_range(0, 29) == 0) begin
                    send_calm = $urandom_range(10, 50);
                end else if ($urandom_range(0, 3) == 0) begin
                    hold_input($urandom_range(1, 15));
                end
            end
        end

        wait_all_results();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
